// ----- src/lpht_pkg.sv -----
// Shared types and constants for the linear-probing hash table.
// No dependencies; used by lpht_ctrl, lpht_datapath and the top level.
package lpht_pkg;

   localparam int MODE_W   = 2;
   localparam int KEY_W    = 31;
   localparam int PAY_W    = 32;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 8;

   typedef enum logic [MODE_W-1:0] {
      MODE_SEARCH = 2'd0,
      MODE_INSERT = 2'd1,
      MODE_DELETE = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      RS_FOUND     = 3'd0,
      RS_NOT_FOUND = 3'd1,
      RS_INSERTED  = 3'd2,
      RS_FULL      = 3'd3,
      RS_DELETED   = 3'd4
   } rsp_status_type;

   typedef enum logic [1:0] {
      SLOT_EMPTY   = 2'd0,
      SLOT_USED    = 2'd1,
      SLOT_DELETED = 2'd2
   } slot_state_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_RECIP,
      S_SCALE,
      S_REDUCE,
      S_HOME,
      S_READ,
      S_CHECK,
      S_RESP
   } fsm_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic           accept;
      logic           recip;
      logic           scale;
      logic           reduce;
      logic           home;
      logic           rd;
      logic           step;
      logic           wr;
      slot_state_type wr_state;
      logic           kv_wr;
      logic           finish;
      rsp_status_type res_status;
      logic           res_slot;
      logic           res_data;
      logic           out_load;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              used;
      logic              empty;
      logic              key_match;
      logic              lap_end;
      logic              idx_last;
      logic              out_free;
   } dp_stat_type;

endpackage

// ----- src/lpht_datapath.sv -----
// Datapath of the hash table: request registers, home-slot reduction,
// probe index, slot memories and result registers. Depends on lpht_pkg.
module lpht_datapath #(
   parameter int TABLE_SIZE   = 256,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  lpht_pkg::ctrl_cmd_type          cmd,
   output lpht_pkg::dp_stat_type           stat,
   input  logic [lpht_pkg::MODE_W-1:0]     req_mode,
   input  logic [lpht_pkg::KEY_W-1:0]      req_key,
   input  logic [lpht_pkg::PAY_W-1:0]      req_payload,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [lpht_pkg::STATUS_W-1:0]   rsp_status,
   output logic [lpht_pkg::PAY_W-1:0]      rsp_data_out,
   output logic [lpht_pkg::SLOT_W-1:0]     rsp_slot
);

   localparam int KEY_W  = lpht_pkg::KEY_W;
   localparam int IDX_W  = $clog2(TABLE_SIZE);
   localparam int NW     = $clog2(TABLE_SIZE + 1);
   localparam int QN_W   = KEY_W + NW;
   localparam int DATA_W = (PAYLOAD_BITS < lpht_pkg::PAY_W) ? PAYLOAD_BITS : lpht_pkg::PAY_W;
   localparam logic [63:0] RECIP_WIDE = (64'd1 << 32) / 64'(TABLE_SIZE);
   localparam logic [31:0] RECIP      = RECIP_WIDE[31:0];
   localparam logic [NW:0] SIZE_R     = (NW + 1)'(TABLE_SIZE);
   localparam logic [IDX_W-1:0] LAST  = IDX_W'(TABLE_SIZE - 1);

   logic [lpht_pkg::MODE_W-1:0] mode_ff;
   logic [KEY_W-1:0]            key_ff;
   logic [DATA_W-1:0]           pay_ff;
   logic [KEY_W-1:0]            quot_ff;
   logic [KEY_W-1:0]            qn_ff;
   logic [NW:0]                 rem_ff;
   logic [IDX_W-1:0]            idx_ff;
   logic [IDX_W-1:0]            cnt_ff;

   logic [1:0]                  state_mem [TABLE_SIZE];
   logic [KEY_W-1:0]            key_mem   [TABLE_SIZE];
   logic [DATA_W-1:0]           data_mem  [TABLE_SIZE];
   logic [1:0]                  state_rd_ff;
   logic [KEY_W-1:0]            key_rd_ff;
   logic [DATA_W-1:0]           data_rd_ff;

   logic [lpht_pkg::STATUS_W-1:0] res_status_ff;
   logic [DATA_W-1:0]             res_data_ff;
   logic [IDX_W-1:0]              res_slot_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [lpht_pkg::STATUS_W-1:0] out_status_ff;
   logic [DATA_W-1:0]             out_data_ff;
   logic [IDX_W-1:0]              out_slot_ff;

   logic [62:0]      prod;
   logic [QN_W-1:0]  qn_full;
   logic [KEY_W-1:0] rem_full;
   logic [NW:0]      home_full;
   logic [IDX_W-1:0] idx_next;

   // Reciprocal estimate of key / TABLE_SIZE, low by at most one.
   assign prod      = 63'(key_ff) * 63'(RECIP);
   assign qn_full   = QN_W'(quot_ff) * QN_W'(TABLE_SIZE);
   assign rem_full  = key_ff - qn_ff;
   assign home_full = (rem_ff >= SIZE_R) ? (rem_ff - SIZE_R) : rem_ff;
   assign idx_next  = (idx_ff == LAST) ? '0 : (idx_ff + 1'b1);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff <= req_mode;
         key_ff  <= req_key;
         pay_ff  <= req_payload[DATA_W-1:0];
      end
      if (cmd.recip)  quot_ff <= prod[62:32];
      if (cmd.scale)  qn_ff   <= qn_full[KEY_W-1:0];
      if (cmd.reduce) rem_ff  <= rem_full[NW:0];
   end

   // Probe index doubles as the sweep address of the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.home) begin
         idx_ff <= home_full[IDX_W-1:0];
         cnt_ff <= '0;
      end else if (cmd.step) begin
         idx_ff <= idx_next;
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr) state_mem[idx_ff] <= cmd.wr_state;
      if (cmd.rd) state_rd_ff <= state_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.kv_wr) begin
         key_mem[idx_ff]  <= key_ff;
         data_mem[idx_ff] <= pay_ff;
      end
      if (cmd.rd) begin
         key_rd_ff  <= key_mem[idx_ff];
         data_rd_ff <= data_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         res_status_ff <= cmd.res_status;
         res_data_ff   <= cmd.res_data ? data_rd_ff : '0;
         res_slot_ff   <= cmd.res_slot ? idx_ff : '0;
      end
      if (cmd.out_load) begin
         out_status_ff <= res_status_ff;
         out_data_ff   <= res_data_ff;
         out_slot_ff   <= res_slot_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
   end

   assign stat.mode      = mode_ff;
   assign stat.used      = (state_rd_ff == lpht_pkg::SLOT_USED);
   assign stat.empty     = (state_rd_ff == lpht_pkg::SLOT_EMPTY);
   assign stat.key_match = (key_rd_ff == key_ff);
   assign stat.lap_end   = (cnt_ff == LAST);
   assign stat.idx_last  = (idx_ff == LAST);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = out_status_ff;
   assign rsp_data_out = lpht_pkg::PAY_W'(out_data_ff);
   assign rsp_slot     = lpht_pkg::SLOT_W'(out_slot_ff);

endmodule

// ----- src/lpht_ctrl.sv -----
// Controller state machine of the hash table: clearing pass, home-slot
// sequencing, probe loop and result hand-off. Depends on lpht_pkg.
module lpht_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lpht_pkg::dp_stat_type  stat,
   output lpht_pkg::ctrl_cmd_type cmd
);

   lpht_pkg::fsm_state_type state_ff;
   lpht_pkg::fsm_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= lpht_pkg::S_CLEAR;
      else
         state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         lpht_pkg::S_CLEAR: begin
            cmd.wr       = 1'b1;
            cmd.wr_state = lpht_pkg::SLOT_EMPTY;
            cmd.step     = 1'b1;
            if (stat.idx_last) state_in = lpht_pkg::S_IDLE;
         end
         lpht_pkg::S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) state_in = lpht_pkg::S_RECIP;
         end
         lpht_pkg::S_RECIP: begin
            if (stat.mode != lpht_pkg::MODE_SEARCH && stat.mode != lpht_pkg::MODE_INSERT &&
                stat.mode != lpht_pkg::MODE_DELETE) begin
               cmd.finish     = 1'b1;
               cmd.res_status = lpht_pkg::RS_NOT_FOUND;
               state_in       = lpht_pkg::S_RESP;
            end else begin
               cmd.recip = 1'b1;
               state_in  = lpht_pkg::S_SCALE;
            end
         end
         lpht_pkg::S_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = lpht_pkg::S_REDUCE;
         end
         lpht_pkg::S_REDUCE: begin
            cmd.reduce = 1'b1;
            state_in   = lpht_pkg::S_HOME;
         end
         lpht_pkg::S_HOME: begin
            cmd.home = 1'b1;
            state_in = lpht_pkg::S_READ;
         end
         lpht_pkg::S_READ: begin
            cmd.rd   = 1'b1;
            state_in = lpht_pkg::S_CHECK;
         end
         lpht_pkg::S_CHECK: begin
            state_in = lpht_pkg::S_RESP;
            if (stat.mode == lpht_pkg::MODE_INSERT) begin
               if (!stat.used) begin
                  cmd.wr         = 1'b1;
                  cmd.wr_state   = lpht_pkg::SLOT_USED;
                  cmd.kv_wr      = 1'b1;
                  cmd.finish     = 1'b1;
                  cmd.res_status = lpht_pkg::RS_INSERTED;
                  cmd.res_slot   = 1'b1;
               end else if (stat.lap_end) begin
                  cmd.finish     = 1'b1;
                  cmd.res_status = lpht_pkg::RS_FULL;
               end else begin
                  cmd.step = 1'b1;
                  state_in = lpht_pkg::S_READ;
               end
            end else begin
               if (stat.used && stat.key_match) begin
                  cmd.finish   = 1'b1;
                  cmd.res_slot = 1'b1;
                  cmd.res_data = 1'b1;
                  if (stat.mode == lpht_pkg::MODE_DELETE) begin
                     cmd.wr         = 1'b1;
                     cmd.wr_state   = lpht_pkg::SLOT_DELETED;
                     cmd.res_status = lpht_pkg::RS_DELETED;
                  end else begin
                     cmd.res_status = lpht_pkg::RS_FOUND;
                  end
               end else if (stat.empty || stat.lap_end) begin
                  cmd.finish     = 1'b1;
                  cmd.res_status = lpht_pkg::RS_NOT_FOUND;
               end else begin
                  cmd.step = 1'b1;
                  state_in = lpht_pkg::S_READ;
               end
            end
         end
         lpht_pkg::S_RESP: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = lpht_pkg::S_IDLE;
            end
         end
         default: state_in = lpht_pkg::S_IDLE;
      endcase
   end

endmodule

// ----- src/linear_probe_hash_table_core.sv -----
// Top level of the linear-probing hash table: controller plus datapath.
// Depends on lpht_pkg, lpht_ctrl and lpht_datapath.
//
// Usage:
//   Request channel (req_valid/req_ready): mode, key, payload. Mode selects
//   search, insert or delete; the unused mode code answers not found at once.
//   Response channel (rsp_valid/rsp_ready): status, data_out, slot. Every
//   request yields exactly one response, in request order.
//   The home slot is key modulo TABLE_SIZE, taken by a reciprocal multiply,
//   a back-multiply and one compare-subtract. Probing walks forward one slot
//   at a time (registered memory read, then check), wrapping, for at most
//   one full lap of TABLE_SIZE slots. One request is in flight at a time;
//   req_ready returns the cycle after the response is loaded. The probe
//   loop through the slot memory sets the time that a request takes.
//   The response register holds a result while the receiver stalls; a new
//   request may be accepted meanwhile, and its result waits in the datapath
//   until the response register frees up.
//   Reset: synchronous, active high. A clearing pass then marks every slot
//   empty; req_ready stays low until it is done.
module linear_probe_hash_table_core #(
   parameter int TABLE_SIZE   = 256,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [lpht_pkg::MODE_W-1:0]     req_mode,
   input  logic [lpht_pkg::KEY_W-1:0]      req_key,
   input  logic [lpht_pkg::PAY_W-1:0]      req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [lpht_pkg::STATUS_W-1:0]   rsp_status,
   output logic [lpht_pkg::PAY_W-1:0]      rsp_data_out,
   output logic [lpht_pkg::SLOT_W-1:0]     rsp_slot
);

   // Command and status between the sequencer and the datapath.
   lpht_pkg::ctrl_cmd_type cmd;
   lpht_pkg::dp_stat_type  stat;

   lpht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lpht_datapath #(
      .TABLE_SIZE   (TABLE_SIZE),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_mode     (req_mode),
      .req_key      (req_key),
      .req_payload  (req_payload),
      .rsp_ready    (rsp_ready),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_data_out (rsp_data_out),
      .rsp_slot     (rsp_slot)
   );

endmodule
